// ===== hdl/cbss_pkg.sv =====
// Shared types and constants for the counter bracket statistics sequencer.
`default_nettype none

package cbss_pkg;

  // Counter count and fixed field widths of the item, result and configuration payloads
  localparam int unsigned IN_COUNTERS = 4;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned SELECT_W    = 2;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE_MASK   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WARMUP_COUNT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MEASURE_COUNT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRECISE_MODE  = 3'd3;

  // Reset values of the configuration registers
  localparam logic [3:0] ENABLE_MASK_RESET  = 4'hF;
  localparam logic       PRECISE_MODE_RESET = 1'b1;

  // Bracket phase: idle, after start snapshot, between runs, double run pending
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_SINGLE = 4'b0010,
    PH_GAP    = 4'b0100,
    PH_DOUBLE = 4'b1000
  } cbss_phase_t;

  // One input item
  typedef struct packed {
    logic [VALUE_W-1:0]  counter_value_0;
    logic [VALUE_W-1:0]  counter_value_1;
    logic [VALUE_W-1:0]  counter_value_2;
    logic [VALUE_W-1:0]  counter_value_3;
    logic [SELECT_W-1:0] stat_select;
  } cbss_in_t;

  // One result item
  typedef struct packed {
    logic               keep_running;
    logic [COUNT_W-1:0] samples_recorded;
    logic [VALUE_W-1:0] stat_min;
    logic [VALUE_W-1:0] stat_max;
    logic [VALUE_W-1:0] stat_sum;
  } cbss_out_t;

endpackage

`default_nettype wire

// ===== hdl/counter_bracket_stats_sequencer.sv =====
// Top level of the counter bracket statistics sequencer.
// Takes one item per clock cycle, back to back, while out_ready is high. Each item
// passes through registers in turn: an input register holds the item, the sequencing and
// statistics update for that item runs as it moves on, and the result lands in an output
// register. Every item gives exactly one result. The item's state update happens as it moves
// from the input register to the output register, so the rate is set by that single update
// step: one item per cycle while out_ready is high. in_ready follows out_ready
// combinationally when both registers are full. There is no clearing pass after reset.
// Configuration writes are taken in every cycle (cfg_ready is always high).
`default_nettype none

module counter_bracket_stats_sequencer #(
  parameter int unsigned NUM_COUNTERS  = 4,
  parameter int unsigned COUNTER_WIDTH = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // item channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire cbss_pkg::cbss_in_t                  in_data,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output cbss_pkg::cbss_out_t                      out_data,
  // configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [cbss_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [cbss_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [COUNTER_WIDTH-1:0] CNT_ONES = '1;

  typedef logic [NUM_COUNTERS-1:0][COUNTER_WIDTH-1:0] cnt_vec_t;

  // configuration registers
  logic [3:0]                       enable_mask_r;
  logic [cbss_pkg::COUNT_W-1:0]     warmup_r;
  logic [cbss_pkg::COUNT_W-1:0]     measure_r;
  logic                             precise_r;

  // pipeline registers
  logic                             s1_valid_r;
  cbss_pkg::cbss_in_t               s1_data_r;
  logic                             out_valid_r;
  cbss_pkg::cbss_out_t              out_data_r;
  logic                             advance;

  // sequencer and statistics state
  logic [cbss_pkg::COUNT_W-1:0]     call_index_r, call_index_nxt;
  cbss_pkg::cbss_phase_t            phase_r, phase_nxt;
  logic [cbss_pkg::COUNT_W-1:0]     sample_count_r, sample_count_nxt;
  cnt_vec_t                         start_r, start_nxt;
  cnt_vec_t                         single_r, single_nxt;
  cnt_vec_t                         min_r, min_nxt;
  cnt_vec_t                         max_r, max_nxt;
  cnt_vec_t                         sum_r, sum_nxt;

  // per-item combinational values
  cnt_vec_t                         cur_val;
  cnt_vec_t                         fast_delta;
  cnt_vec_t                         rec_delta;
  logic [NUM_COUNTERS-1:0]          counter_en;
  logic                             in_warmup;
  logic                             record_now;
  logic                             more_samples;
  logic [cbss_pkg::COUNT_W-1:0]     call_after;
  cbss_pkg::cbss_out_t              result;

  // handshakes
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // counter readings and enables; counters past the item's fields read zero
  for (genvar gi = 0; gi < NUM_COUNTERS; gi++) begin : g_cnt
    if (gi == 0) begin : g_c0
      assign cur_val[gi] = s1_data_r.counter_value_0[COUNTER_WIDTH-1:0];
    end else if (gi == 1) begin : g_c1
      assign cur_val[gi] = s1_data_r.counter_value_1[COUNTER_WIDTH-1:0];
    end else if (gi == 2) begin : g_c2
      assign cur_val[gi] = s1_data_r.counter_value_2[COUNTER_WIDTH-1:0];
    end else if (gi == 3) begin : g_c3
      assign cur_val[gi] = s1_data_r.counter_value_3[COUNTER_WIDTH-1:0];
    end else begin : g_cz
      assign cur_val[gi] = '0;
    end
    if (gi < cbss_pkg::IN_COUNTERS) begin : g_en
      assign counter_en[gi] = enable_mask_r[gi];
    end else begin : g_enz
      assign counter_en[gi] = 1'b0;
    end
  end

  // deltas: end minus start, and in precise mode double run minus single run clamped at zero
  always_comb begin
    logic [COUNTER_WIDTH:0] diff;
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      fast_delta[i] = cur_val[i] - start_r[i];
      diff = {1'b0, fast_delta[i]} - {1'b0, single_r[i]};
      if (!precise_r) begin
        rec_delta[i] = fast_delta[i];
      end else if (diff[COUNTER_WIDTH]) begin
        rec_delta[i] = '0;
      end else begin
        rec_delta[i] = diff[COUNTER_WIDTH-1:0];
      end
    end
  end

  // sequencer step for the item in the input register
  always_comb begin
    in_warmup   = call_index_r < warmup_r;
    record_now  = !in_warmup && (phase_r != cbss_pkg::PH_IDLE) &&
                  (!precise_r || phase_r == cbss_pkg::PH_DOUBLE);
    call_after  = record_now ? call_index_r + 32'd1 : call_index_r;
    more_samples = (call_after - warmup_r) < measure_r;

    call_index_nxt   = call_index_r;
    phase_nxt        = phase_r;
    sample_count_nxt = sample_count_r;
    start_nxt        = start_r;
    single_nxt       = single_r;
    min_nxt          = min_r;
    max_nxt          = max_r;
    sum_nxt          = sum_r;
    result.keep_running = 1'b1;

    if (in_warmup) begin
      call_index_nxt = call_index_r + 32'd1;
    end else if (phase_r == cbss_pkg::PH_IDLE || record_now) begin
      // close a bracket if one is open, then decide whether to open the next
      call_index_nxt      = call_after;
      result.keep_running = more_samples;
      if (record_now) begin
        sample_count_nxt = sample_count_r + 32'd1;
        for (int i = 0; i < NUM_COUNTERS; i++) begin
          if (counter_en[i]) begin
            if (rec_delta[i] < min_r[i]) min_nxt[i] = rec_delta[i];
            if (rec_delta[i] > max_r[i]) max_nxt[i] = rec_delta[i];
            sum_nxt[i] = sum_r[i] + rec_delta[i];
          end
        end
      end
      if (more_samples) begin
        start_nxt = cur_val;
        phase_nxt = cbss_pkg::PH_SINGLE;
      end else begin
        phase_nxt = cbss_pkg::PH_IDLE;
      end
    end else if (phase_r == cbss_pkg::PH_SINGLE) begin
      // precise mode: keep the single-run delta and restart the bracket
      single_nxt = fast_delta;
      start_nxt  = cur_val;
      phase_nxt  = cbss_pkg::PH_GAP;
    end else begin
      phase_nxt = cbss_pkg::PH_DOUBLE;
    end

    // statistics of the selected counter after this item's update
    result.samples_recorded = sample_count_nxt;
    result.stat_min = cbss_pkg::VALUE_W'(CNT_ONES);
    result.stat_max = '0;
    result.stat_sum = '0;
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      if (32'(s1_data_r.stat_select) == 32'(i)) begin
        result.stat_min = cbss_pkg::VALUE_W'(min_nxt[i]);
        result.stat_max = cbss_pkg::VALUE_W'(max_nxt[i]);
        result.stat_sum = cbss_pkg::VALUE_W'(sum_nxt[i]);
      end
    end
  end

  // control and statistics registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_mask_r  <= cbss_pkg::ENABLE_MASK_RESET;
      warmup_r       <= '0;
      measure_r      <= '0;
      precise_r      <= cbss_pkg::PRECISE_MODE_RESET;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      call_index_r   <= '0;
      phase_r        <= cbss_pkg::PH_IDLE;
      sample_count_r <= '0;
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        min_r[i] <= CNT_ONES;
        max_r[i] <= '0;
        sum_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cbss_pkg::CFG_ENABLE_MASK:   enable_mask_r <= cfg_data[3:0];
          cbss_pkg::CFG_WARMUP_COUNT:  warmup_r      <= cfg_data;
          cbss_pkg::CFG_MEASURE_COUNT: measure_r     <= cfg_data;
          cbss_pkg::CFG_PRECISE_MODE:  precise_r     <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        call_index_r   <= call_index_nxt;
        phase_r        <= phase_nxt;
        sample_count_r <= sample_count_nxt;
        min_r          <= min_nxt;
        max_r          <= max_nxt;
        sum_r          <= sum_nxt;
      end
    end
  end

  // payload registers and snapshots
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
      start_r    <= start_nxt;
      single_r   <= single_nxt;
    end
  end

`ifndef SYNTH
  // no sample is counted unless an item moves to the output register
  a_samples_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(sample_count_r))
    else $error("sample count changed without an item");

  // a finished result leaves the bracket closed
  a_stop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !result.keep_running) |=> phase_r == cbss_pkg::PH_IDLE)
    else $error("bracket open after measurement finished");

  // a held item is not dropped while the output side stalls
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_data_r)))
    else $error("stalled item lost");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_counter_bracket_stats_sequencer.sv =====
// Self-checking testbench for the counter bracket statistics sequencer.
`timescale 1ns / 1ps

module tb_counter_bracket_stats_sequencer;

  localparam int unsigned NUM_CNT         = cbss_pkg::IN_COUNTERS;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned SEGS_PER_MODE   = 5;

  // DUT connections, all inputs known from time zero
  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic                             in_valid  = 1'b0;
  logic                             in_ready;
  cbss_pkg::cbss_in_t               in_data   = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  cbss_pkg::cbss_out_t              out_data;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [cbss_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [cbss_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  counter_bracket_stats_sequencer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the registers
  logic [3:0]         cur_enable;
  logic [31:0]        cur_warmup;
  logic [31:0]        cur_measure;
  logic               cur_precise;

  // Predictor copy of the sequencing and statistics state
  logic [31:0]                  calls_seen;
  logic [31:0]                  samples_taken;
  cbss_pkg::cbss_phase_t        bracket;
  logic [cbss_pkg::VALUE_W-1:0] base_snap     [NUM_CNT];
  logic [cbss_pkg::VALUE_W-1:0] one_run_delta [NUM_CNT];
  logic [cbss_pkg::VALUE_W-1:0] lo_delta      [NUM_CNT];
  logic [cbss_pkg::VALUE_W-1:0] hi_delta      [NUM_CNT];
  logic [cbss_pkg::VALUE_W-1:0] acc_delta     [NUM_CNT];

  // Stimulus and scoreboard storage
  cbss_pkg::cbss_in_t           pending_calls[$];
  cbss_pkg::cbss_out_t          expected_results[$];
  logic [cbss_pkg::VALUE_W-1:0] trend [NUM_CNT];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;
  int unsigned calls_taken = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  logic        in_took = 1'b0;

  // Clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Predictor reset
  task automatic reset_predictor();
    cur_enable    = cbss_pkg::ENABLE_MASK_RESET;
    cur_warmup    = '0;
    cur_measure   = '0;
    cur_precise   = cbss_pkg::PRECISE_MODE_RESET;
    calls_seen    = '0;
    samples_taken = '0;
    bracket       = cbss_pkg::PH_IDLE;
    for (int i = 0; i < NUM_CNT; i++) begin
      base_snap[i]     = '0;
      one_run_delta[i] = '0;
      lo_delta[i]      = '1;
      hi_delta[i]      = '0;
      acc_delta[i]     = '0;
    end
  endtask

  // One call of the measurement loop: advance the bracket, return the expected result
  function automatic cbss_pkg::cbss_out_t step_sequencer(input cbss_pkg::cbss_in_t item);
    logic [cbss_pkg::VALUE_W-1:0] now_val [NUM_CNT];
    logic [cbss_pkg::VALUE_W-1:0] delta   [NUM_CNT];
    logic [cbss_pkg::VALUE_W-1:0] dbl;
    logic                         keep;
    logic                         done;
    cbss_pkg::cbss_out_t          res;
    now_val[0] = item.counter_value_0;
    now_val[1] = item.counter_value_1;
    now_val[2] = item.counter_value_2;
    now_val[3] = item.counter_value_3;
    keep = 1'b1;
    if (calls_seen < cur_warmup) begin
      calls_seen = calls_seen + 1;
    end else begin
      done = 1'b0;
      while (!done) begin
        if (bracket == cbss_pkg::PH_IDLE) begin
          // open a new bracket unless enough samples are in
          if (calls_seen - cur_warmup >= cur_measure) begin
            keep = 1'b0;
          end else begin
            for (int i = 0; i < NUM_CNT; i++) base_snap[i] = now_val[i];
            bracket = cbss_pkg::PH_SINGLE;
          end
          done = 1'b1;
        end else if (cur_precise && bracket == cbss_pkg::PH_SINGLE) begin
          for (int i = 0; i < NUM_CNT; i++) begin
            one_run_delta[i] = now_val[i] - base_snap[i];
            base_snap[i]     = now_val[i];
          end
          bracket = cbss_pkg::PH_GAP;
          done = 1'b1;
        end else if (cur_precise && bracket == cbss_pkg::PH_GAP) begin
          bracket = cbss_pkg::PH_DOUBLE;
          done = 1'b1;
        end else begin
          // close the bracket; fast mode closes from any open phase
          for (int i = 0; i < NUM_CNT; i++) begin
            if (cur_precise) begin
              dbl = now_val[i] - base_snap[i];
              delta[i] = (dbl < one_run_delta[i]) ? '0 : dbl - one_run_delta[i];
            end else begin
              delta[i] = now_val[i] - base_snap[i];
            end
            if (cur_enable[i]) begin
              if (delta[i] < lo_delta[i]) lo_delta[i] = delta[i];
              if (delta[i] > hi_delta[i]) hi_delta[i] = delta[i];
              acc_delta[i] = acc_delta[i] + delta[i];
            end
          end
          samples_taken = samples_taken + 1;
          calls_seen = calls_seen + 1;
          bracket = cbss_pkg::PH_IDLE;
        end
      end
    end
    res.keep_running     = keep;
    res.samples_recorded = samples_taken;
    res.stat_min         = lo_delta[item.stat_select];
    res.stat_max         = hi_delta[item.stat_select];
    res.stat_sum         = acc_delta[item.stat_select];
    return res;
  endfunction

  task automatic compare_field(input string field,
                               input logic [cbss_pkg::VALUE_W-1:0] want,
                               input logic [cbss_pkg::VALUE_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  // Result checking, prediction on acceptance, register tracking and watchdog
  always @(posedge clk) begin : monitor
    cbss_pkg::cbss_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          want = expected_results.pop_front();
          compare_field("keep_running", cbss_pkg::VALUE_W'(want.keep_running),
                        cbss_pkg::VALUE_W'(out_data.keep_running));
          compare_field("samples_recorded", cbss_pkg::VALUE_W'(want.samples_recorded),
                        cbss_pkg::VALUE_W'(out_data.samples_recorded));
          compare_field("stat_min", want.stat_min, out_data.stat_min);
          compare_field("stat_max", want.stat_max, out_data.stat_max);
          compare_field("stat_sum", want.stat_sum, out_data.stat_sum);
          results_checked++;
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(step_sequencer(in_data));
        calls_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cbss_pkg::CFG_ENABLE_MASK:   cur_enable  = cfg_data[3:0];
          cbss_pkg::CFG_WARMUP_COUNT:  cur_warmup  = cfg_data;
          cbss_pkg::CFG_MEASURE_COUNT: cur_measure = cfg_data;
          cbss_pkg::CFG_PRECISE_MODE:  cur_precise = cfg_data[0];
          default: ;
        endcase
        reg_writes++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
    in_took <= rst_n && in_valid && in_ready;
  end

  // Item driver: next item only once the current one is gone
  always @(negedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_calls.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data  <= pending_calls.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin : receiver
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_done != hold_asks) begin
      hold_done++;
      hold_left = HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [cbss_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [cbss_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Block until every queued item has been taken and every result has come back
  task automatic wait_idle();
    while (pending_calls.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic push_call(input logic [cbss_pkg::VALUE_W-1:0] v0,
                           input logic [cbss_pkg::VALUE_W-1:0] v1,
                           input logic [cbss_pkg::VALUE_W-1:0] v2,
                           input logic [cbss_pkg::VALUE_W-1:0] v3,
                           input logic [cbss_pkg::SELECT_W-1:0] sel);
    cbss_pkg::cbss_in_t item;
    item.counter_value_0 = v0;
    item.counter_value_1 = v1;
    item.counter_value_2 = v2;
    item.counter_value_3 = v3;
    item.stat_select     = sel;
    pending_calls.push_back(item);
  endtask

  // Counters mostly creep upward; now and then they jump or sit just below wrap
  function automatic cbss_pkg::cbss_in_t next_call();
    cbss_pkg::cbss_in_t           item;
    logic [cbss_pkg::VALUE_W-1:0] v [NUM_CNT];
    int unsigned                  pick;
    for (int i = 0; i < NUM_CNT; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)
        trend[i] = {$urandom, $urandom};
      else if (pick < 6)
        trend[i] = {cbss_pkg::VALUE_W{1'b1}} -
                   cbss_pkg::VALUE_W'($urandom_range(0, 400));
      else
        trend[i] = trend[i] + cbss_pkg::VALUE_W'($urandom_range(0, 500));
      v[i] = trend[i];
    end
    item.counter_value_0 = v[0];
    item.counter_value_1 = v[1];
    item.counter_value_2 = v[2];
    item.counter_value_3 = v[3];
    item.stat_select     = cbss_pkg::SELECT_W'($urandom_range(0, 3));
    return item;
  endfunction

  // Restart measuring a few calls from now with a fresh setting
  task automatic arm_segment(input logic [3:0] mask, input logic precise,
                             input int unsigned warm_extra, input logic [31:0] n_samples);
    write_reg(cbss_pkg::CFG_ENABLE_MASK, cbss_pkg::CFG_DATA_W'(mask));
    write_reg(cbss_pkg::CFG_PRECISE_MODE, cbss_pkg::CFG_DATA_W'(precise));
    write_reg(cbss_pkg::CFG_WARMUP_COUNT, calls_seen + warm_extra);
    write_reg(cbss_pkg::CFG_MEASURE_COUNT, n_samples);
  endtask

  initial begin : stimulus
    int unsigned seg_items;
    int unsigned pick;
    logic [31:0] n_samples;
    logic [3:0]  mask;
    logic        precise;
    reset_predictor();
    for (int i = 0; i < NUM_CNT; i++) trend[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero measurement count: every call reports finished with empty statistics
    push_call('0, '0, '0, '0, 2'd0);
    push_call('1, '1, '1, '1, 2'd3);
    wait_idle();

    // precise brackets after two warmup calls: wrapped single run, clamped sample
    arm_segment(4'hF, 1'b1, 2, 2);
    push_call(5, 5, 5, 5, 2'd1);
    push_call(9, 9, 9, 9, 2'd2);
    push_call(0, '1, 100, 64'h8000_0000_0000_0000, 2'd0);
    push_call(100, 5, 300, 64'h8000_0000_0000_0010, 2'd1);
    push_call(150, 7, 350, 64'h8000_0000_0000_0011, 2'd2);
    push_call(150, 20, 900, 64'h8000_0000_0000_0030, 2'd3);
    push_call(400, 40, 1000, 64'h7FFF_FFFF_FFFF_FFFF, 2'd0);
    push_call(401, 41, 1001, 0, 2'd1);
    push_call(800, 80, 2000, 64'h8000_0000_0000_0000, 2'd3);
    push_call(900, 90, 2100, 1, 2'd2);
    wait_idle();

    // fast brackets with half the counters masked, deltas across the wrap
    arm_segment(4'b0101, 1'b0, 0, 3);
    push_call('1, '1, '1, '1, 2'd0);
    push_call('0, '0, '0, '0, 2'd1);
    push_call('1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, '0, 2'd2);
    push_call(64'hAAAA_AAAA_AAAA_AAAA, '0, 64'h5555_5555_5555_5555, '1, 2'd3);
    push_call(7, 7, 7, 7, 2'd0);
    wait_idle();

    // largest warmup and measure counts, no counter enabled
    write_reg(cbss_pkg::CFG_ENABLE_MASK, cbss_pkg::CFG_DATA_W'(4'h0));
    write_reg(cbss_pkg::CFG_PRECISE_MODE, cbss_pkg::CFG_DATA_W'(1'b1));
    write_reg(cbss_pkg::CFG_MEASURE_COUNT, 32'hFFFF_FFFF);
    write_reg(cbss_pkg::CFG_WARMUP_COUNT, 32'hFFFF_FFFF);
    pending_calls.push_back(next_call());
    pending_calls.push_back(next_call());
    wait_idle();
    write_reg(cbss_pkg::CFG_WARMUP_COUNT, 32'h0);
    repeat (3) pending_calls.push_back(next_call());
    wait_idle();
    // switch to fast mode while a double run is pending
    write_reg(cbss_pkg::CFG_PRECISE_MODE, cbss_pkg::CFG_DATA_W'(1'b0));
    pending_calls.push_back(next_call());
    wait_idle();

    // random segments under four idling patterns
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      for (int seg = 0; seg < SEGS_PER_MODE; seg++) begin
        wait_idle();
        pick      = $urandom_range(0, 9);
        precise   = 1'($urandom_range(0, 1));
        seg_items = $urandom_range(80, 115);
        if (precise)
          n_samples = seg_items / 3 - $urandom_range(0, 3);
        else
          n_samples = seg_items - $urandom_range(0, 8);
        if (pick == 0) n_samples = '0;
        if (pick == 1) n_samples = '1;
        if (pick == 2)
          mask = 4'h0;
        else if (pick == 3)
          mask = 4'hF;
        else
          mask = 4'($urandom_range(0, 15));
        arm_segment(mask, precise, $urandom_range(0, 4), n_samples);
        if (mode == 2 && seg == 1) hold_asks++;
        for (int k = 0; k < seg_items; k++) begin
          // in each mode's third segment the sender pauses halfway until the block has handed back everything
          if (seg == 2 && k == seg_items / 2) wait_idle();
          pending_calls.push_back(next_call());
        end
      end
    end

    // drain and let any stray result show up
    wait_idle();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatch_count += expected_results.size();
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    end
    $display("Covered %0d calls, %0d results checked, %0d samples folded,",
             calls_taken, results_checked, samples_taken);
    $display("%0d register writes across fast/precise and idling patterns, %0d mismatches",
             reg_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cbss_pkg.sv
hdl/counter_bracket_stats_sequencer.sv
verif/tb_counter_bracket_stats_sequencer.sv
